FILE: sv/bpagc_pkg.sv
`default_nettype none
package bpagc_pkg;

    localparam int BLOCK_LEN_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int STEP_W   = 16;

    // shared multiplier: unsigned gain as signed 25 bits, operand as signed 17 bits
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = SAMPLE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h010000;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'hFFFFFF;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd3277;
    localparam logic signed [PROD_W-1:0] GAIN_ONE_Q28 = PROD_W'(64'd1 << 28);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       out_last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GMUL,
        ST_GUPD,
        ST_READ,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

FILE: sv/bpagc_store.sv
`default_nettype none
module bpagc_store #(
    parameter int DEPTH = bpagc_pkg::BLOCK_LEN_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [bpagc_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic                          i_re,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [bpagc_pkg::SAMPLE_W-1:0] o_rdata
);

    logic [bpagc_pkg::SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/bpagc_mul.sv
`default_nettype none
module bpagc_mul (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [bpagc_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [bpagc_pkg::MUL_B_W-1:0] i_b,
    output logic      signed [bpagc_pkg::PROD_W-1:0]  o_prod
);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod <= bpagc_pkg::PROD_W'(i_a) * bpagc_pkg::PROD_W'(i_b);
        end
    end

endmodule
`default_nettype wire

FILE: sv/block_peak_agc_core.sv
`default_nettype none
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------
// input    | i_start, o_busy        | i_item (t_in_item)
// result   | o_strobe               | o_result (t_out_item)
// config   | i_cfg_we               | i_cfg_wdata (gain_step, Q0.16)
//
// A sample is taken while the block is loading. The sample that closes a
// block starts the replay, and the block stays busy through the gain update
// through the shared multiplier, then one memory read per cycle for the n
// stored samples, then the draining of the read/multiply/round pipeline.
// Results come one per cycle and cannot be stalled. Reset clears the control
// state and restores the default gain and step.
module block_peak_agc_core #(
    parameter int BLOCK_LEN = bpagc_pkg::BLOCK_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire bpagc_pkg::t_in_item           i_item,
    output logic                               o_strobe,
    output bpagc_pkg::t_out_item               o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpagc_pkg::STEP_W-1:0]  i_cfg_wdata
);

    localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int CW = $clog2(BLOCK_LEN + 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(BLOCK_LEN);

    localparam int SW = bpagc_pkg::SAMPLE_W;
    localparam int GW = bpagc_pkg::GAIN_W;
    localparam int PW = bpagc_pkg::PROD_W;

    bpagc_pkg::t_state r_state, n_state;

    logic [CW-1:0]           r_fill;
    logic [SW-1:0]           r_peak;
    logic [GW-1:0]           r_gain;
    logic [bpagc_pkg::STEP_W-1:0] r_step;
    logic [AW-1:0]           r_rd_addr;
    logic                    r_v1, r_l1, r_v2, r_l2;

    logic                    w_accept, w_close, w_issue_last;
    logic [CW-1:0]           w_fill_inc;
    logic [SW-1:0]           w_mag;
    logic [SW-1:0]           w_rdata;
    logic                    w_rd_en, w_mul_peak;
    logic signed [bpagc_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_round;
    logic signed [PW-17:0]   w_shift;
    logic signed [SW-1:0]    w_sat;
    logic [GW:0]             w_gain_up;

    assign w_accept   = i_start && !o_busy;
    assign w_fill_inc = r_fill + CW'(1);
    assign w_close    = i_item.block_end || (w_fill_inc == FILL_FULL);
    assign w_mag      = i_item.sample_in[SW-1] ? SW'(~i_item.sample_in + SW'(1))
                                               : i_item.sample_in;
    assign w_issue_last = (CW'(r_rd_addr) == r_fill - CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpagc_pkg::ST_LOAD:  if (w_accept && w_close) n_state = bpagc_pkg::ST_GMUL;
            bpagc_pkg::ST_GMUL:  n_state = bpagc_pkg::ST_GUPD;
            bpagc_pkg::ST_GUPD:  n_state = bpagc_pkg::ST_READ;
            bpagc_pkg::ST_READ:  if (w_issue_last) n_state = bpagc_pkg::ST_DRAIN;
            bpagc_pkg::ST_DRAIN: if (!r_v1 && !r_v2) n_state = bpagc_pkg::ST_LOAD;
            default:             n_state = bpagc_pkg::ST_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_busy     = 1'b1;
        w_rd_en    = 1'b0;
        w_mul_peak = 1'b0;
        unique case (r_state)
            bpagc_pkg::ST_LOAD:  o_busy = 1'b0;
            bpagc_pkg::ST_GMUL:  w_mul_peak = 1'b1;
            bpagc_pkg::ST_GUPD:  ;
            bpagc_pkg::ST_READ:  w_rd_en = 1'b1;
            bpagc_pkg::ST_DRAIN: ;
            default:             ;
        endcase
    end

    bpagc_store #(
        .DEPTH (BLOCK_LEN),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_item.sample_in),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_mul_b = w_mul_peak ? {1'b0, r_peak} : {w_rdata[SW-1], w_rdata};

    bpagc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_peak || r_v1),
        .i_a    ({1'b0, r_gain}),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // round half up, then saturate to Q4.12
    assign w_round = w_prod + PW'(32768);
    assign w_shift = w_round[PW-1:16];
    always_comb begin
        priority if (w_shift > (PW-16)'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_shift < -(PW-16)'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_shift[SW-1:0];
        end
    end

    assign w_gain_up = {1'b0, r_gain} + (GW+1)'(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpagc_pkg::ST_LOAD;
            r_fill   <= '0;
            r_peak   <= '0;
            r_gain   <= bpagc_pkg::GAIN_RESET;
            r_step   <= bpagc_pkg::STEP_RESET;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_v1     <= w_rd_en;
            r_v2     <= r_v1;
            o_strobe <= r_v2;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_fill <= w_fill_inc;
                if (w_mag > r_peak) begin
                    r_peak <= w_mag;
                end
            end
            if (r_state == bpagc_pkg::ST_GUPD) begin
                r_peak <= '0;
                priority if (r_peak != '0 && w_prod < bpagc_pkg::GAIN_ONE_Q28) begin
                    r_gain <= w_gain_up[GW] ? bpagc_pkg::GAIN_MAX : w_gain_up[GW-1:0];
                end else if (w_prod > bpagc_pkg::GAIN_ONE_Q28) begin
                    r_gain <= (r_gain > GW'(r_step)) ? r_gain - GW'(r_step) : '0;
                end else begin
                    r_gain <= r_gain;
                end
            end
            if (r_state == bpagc_pkg::ST_DRAIN && n_state == bpagc_pkg::ST_LOAD) begin
                r_fill <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == bpagc_pkg::ST_GUPD) begin
            r_rd_addr <= '0;
        end else if (w_rd_en) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        r_l1 <= w_issue_last;
        r_l2 <= r_l1;
        if (r_v2) begin
            o_result.sample_out <= w_sat;
            o_result.out_last   <= r_l2;
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/block_peak_agc_core_tb.sv
`timescale 1ns / 100ps
module block_peak_agc_core_tb;

    localparam int BLOCK_LEN = bpagc_pkg::BLOCK_LEN_DEF;
    localparam longint unsigned GAIN_UNITY = 64'd1 << 28;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    logic            o_busy;
    bpagc_pkg::t_in_item  i_item = '0;
    logic            o_strobe;
    bpagc_pkg::t_out_item o_result;
    logic            i_cfg_we = 1'b0;
    logic [bpagc_pkg::STEP_W-1:0] i_cfg_wdata = '0;

    block_peak_agc_core #(
        .BLOCK_LEN(BLOCK_LEN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    bpagc_pkg::t_in_item  pending_items[$];
    bpagc_pkg::t_out_item scaled_outputs[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    bit        took_item = 1'b0;

    // AGC state mirror
    logic signed [bpagc_pkg::SAMPLE_W-1:0] held_samples [BLOCK_LEN];
    logic [bpagc_pkg::SAMPLE_W-1:0]        held_peak;
    int unsigned                           held_count;
    logic [bpagc_pkg::GAIN_W-1:0]          agc_gain;
    logic [bpagc_pkg::STEP_W-1:0]          agc_step;

    task automatic agc_absorb(input bpagc_pkg::t_in_item it);
        int              s;
        int unsigned     mag;
        longint unsigned prod;
        int unsigned     raised;
        longint          scaled;
        bpagc_pkg::t_out_item res;
        s = $signed(it.sample_in);
        mag = (s < 0) ? -s : s;
        if (held_count >= BLOCK_LEN) held_count = 0;
        held_samples[held_count] = it.sample_in;
        held_count++;
        if (mag > held_peak) held_peak = 16'(mag);
        if (!it.block_end && held_count < BLOCK_LEN) return;

        prod = 64'(agc_gain) * 64'(held_peak);
        if (held_peak != 0 && prod < GAIN_UNITY) begin
            raised = agc_gain + agc_step;
            agc_gain = (raised > bpagc_pkg::GAIN_MAX) ? bpagc_pkg::GAIN_MAX
                                                      : raised[bpagc_pkg::GAIN_W-1:0];
        end else if (prod > GAIN_UNITY) begin
            agc_gain = (agc_gain > agc_step) ? agc_gain - agc_step : '0;
        end

        for (int k = 0; k < held_count; k++) begin
            scaled = longint'(held_samples[k]) * longint'(agc_gain) + 32768;
            scaled = scaled >>> 16;
            if (scaled > 32767) scaled = 32767;
            if (scaled < -32768) scaled = -32768;
            res.sample_out = 16'(scaled);
            res.out_last = (k == held_count - 1);
            scaled_outputs.push_back(res);
        end
        held_count = 0;
        held_peak = '0;
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin
        bpagc_pkg::t_out_item want;
        if (!i_rst_n) begin
            took_item = 1'b0;
            held_count = 0;
            held_peak = '0;
            agc_gain = bpagc_pkg::GAIN_RESET;
            agc_step = bpagc_pkg::STEP_RESET;
        end else begin
            took_item = i_start && !o_busy;
            if (i_cfg_we) agc_step = i_cfg_wdata;
            if (took_item) agc_absorb(i_item);
            if (o_strobe) begin
                if (scaled_outputs.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer: sample_out %0d out_last %0b",
                             $time, o_result.sample_out, o_result.out_last);
                end else begin
                    want = scaled_outputs.pop_front();
                    if (o_result.sample_out !== want.sample_out) begin
                        mismatches++;
                        $display("%0t: sample_out expected %0d actual %0d",
                                 $time, want.sample_out, o_result.sample_out);
                    end
                    if (o_result.out_last !== want.out_last) begin
                        mismatches++;
                        $display("%0t: out_last expected %0b actual %0b",
                                 $time, want.out_last, o_result.out_last);
                    end
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || took_item) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_item <= pending_items.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    task automatic add_item(input logic signed [bpagc_pkg::SAMPLE_W-1:0] s,
                            input logic last);
        bpagc_pkg::t_in_item it;
        it.sample_in = s;
        it.block_end = last;
        pending_items.push_back(it);
    endtask

    function automatic logic signed [bpagc_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        int v;
        sel = $urandom_range(9);
        case (sel)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3, 4: begin
                v = $urandom_range(64);
                return $urandom_range(1) ? 16'(-v) : 16'(v);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random_blocks(input int target);
        int added;
        int sel;
        int len;
        logic last;
        added = 0;
        while (added < target) begin
            sel = $urandom_range(99);
            if (sel < 60) len = $urandom_range(1, 8);
            else if (sel < 85) len = $urandom_range(9, BLOCK_LEN - 1);
            else len = BLOCK_LEN;
            for (int k = 0; k < len; k++) begin
                if (k != len - 1) last = 1'b0;
                else if (len == BLOCK_LEN) last = $urandom_range(1);
                else last = 1'b1;
                add_item(pick_sample(), last);
            end
            added += len;
        end
    endtask

    task automatic write_step(input logic [bpagc_pkg::STEP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all transfers done, all results seen, then let the block settle
    task automatic drain();
        while (pending_items.size() != 0 || i_start || scaled_outputs.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        int m;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // gain 1.0 at reset, step 0.05
        write_step(bpagc_pkg::STEP_RESET);
        send_idle_pct = 11;
        add_item(16'sd4096, 1'b1);             // product exactly 1.0: hold
        add_item(16'sd0, 1'b0);
        add_item(16'sd0, 1'b1);                // zero peak: hold
        add_item(16'sh8000, 1'b0);
        add_item(16'sh7FFF, 1'b0);
        add_item(16'sd2048, 1'b0);
        add_item(-16'sd2048, 1'b0);
        add_item(-16'sd1, 1'b0);
        add_item(16'sd1, 1'b1);                // big peak: gain falls
        drain();

        // largest step: floor, then climb to ceiling
        write_step(16'hFFFF);
        add_item(16'sh7FFF, 1'b0);
        add_item(-16'sd5, 1'b1);
        add_item(-16'sd3, 1'b1);
        add_item(16'sd7, 1'b1);
        for (int k = 0; k < 260; k++) begin
            m = $urandom_range(1, 16);
            add_item($urandom_range(1) ? 16'(-m) : 16'(m), 1'b1);
        end
        add_random_blocks(60);
        drain();

        write_step(16'h0000);
        send_idle_pct = 72;
        add_random_blocks(60);
        drain();

        write_step(16'($urandom_range(1, 65534)));
        send_idle_pct = 0;
        add_random_blocks(80);
        drain();

        if (mismatches == 0 && scaled_outputs.size() == 0) begin
            $display("block_peak_agc_core regression: pass");
        end else begin
            $display("block_peak_agc_core regression: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("block_peak_agc_core regression: fail");
        $finish;
    end

endmodule
